[rtl/core/assert_macros.svh]
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tsc_pkg.sv]
`default_nettype none

package tsc_pkg;

  localparam int unsigned CHANS     = 16;
  localparam int unsigned PAIRS     = 8;
  localparam int unsigned BOARD_W   = 3;
  localparam int unsigned PAIR_W    = 3;
  localparam int unsigned BINF_W    = 3;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned CORR_W    = 12;
  localparam int unsigned MAP_W     = 4;
  localparam int unsigned LOAD_W    = 13;
  localparam int unsigned SUM_W     = 14;
  localparam int unsigned J_W       = 14;
  localparam int unsigned DIFF_W    = 15;
  localparam int unsigned NUM_W     = 21;
  localparam int unsigned K_W       = 3;
  localparam int unsigned MODULE_MID = 3;
  localparam int unsigned SUM_SHIFT = 3;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QCNT_W    = 2;

  typedef enum logic [1:0] {
    CMD_COMPUTE   = 2'd0,
    CMD_LOAD_EDGE = 2'd1,
    CMD_LOAD_CORR = 2'd2,
    CMD_LOAD_MAP  = 2'd3
  } command_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_MONITOR  = 3'd1,
    ST_WINDOW   = 3'd2,
    ST_UNMAPPED = 3'd3,
    ST_LOADED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_TAC_LOWER  = 2'd0,
    REG_TAC_UPPER  = 2'd1,
    REG_DIFF_LIMIT = 2'd2,
    REG_SKIP_EVEN  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    IT_COMPUTE = 3'd0,
    IT_DIRECT  = 3'd1,
    IT_EDGE    = 3'd2,
    IT_CORR    = 3'd3,
    IT_MAP     = 3'd4
  } item_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SCAN  = 2'd1,
    BK_CHECK = 2'd2,
    BK_MATH  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] tac_lower;
    logic [SAMPLE_W-1:0] tac_upper;
    logic [SAMPLE_W-1:0] diff_limit;
    logic                skip_even;
  } cfg_t;

  typedef struct packed {
    item_kind_e          kind;
    status_e             status;
    logic [BOARD_W-1:0]  board;
    logic [PAIR_W-1:0]   pair;
    logic                side;
    logic [BINF_W-1:0]   bin;
    logic [CORR_W-1:0]   word;
    logic [SAMPLE_W-1:0] tac0;
    logic [SAMPLE_W-1:0] tac1;
    logic [SAMPLE_W-1:0] adc0;
    logic [SAMPLE_W-1:0] adc1;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/qt_tac_slew_correct_sum.sv]
// channel   handshake            payload
// item      start_i / busy_o     command_i board_i pair_i side_i bin_i load_value_i
//                                tac_first_i tac_second_i adc_first_i adc_second_i
// config    cfg_we_i             cfg_addr_i cfg_wdata_i
// result    done_o (strobe)      tac_sum_o status_o
//
// a word is taken when start_i is high and busy_o low; busy_o rises when the
// two-entry queue between classifier and executor is full
// loads and early rejects set the registered done_o straight from the executor's idle
// state; a pair goes through the bin scan, which reads one edge of one side per cycle
// from the edge memory, then window check and sum
// reset is asynchronous and clears control and the config registers only; tables are
// undefined until loaded. results cannot be stalled
`default_nettype none

`include "assert_macros.svh"

module qt_tac_slew_correct_sum #(
  parameter int unsigned BOARDS    = 8,
  parameter int unsigned SLEW_BINS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_addr_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  cfg_wdata_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [tsc_pkg::BOARD_W-1:0]   board_i,
  input  wire logic [tsc_pkg::PAIR_W-1:0]    pair_i,
  input  wire logic                          side_i,
  input  wire logic [tsc_pkg::BINF_W-1:0]    bin_i,
  input  wire logic signed [tsc_pkg::LOAD_W-1:0] load_value_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  tac_first_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  tac_second_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  adc_first_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  adc_second_i,
  output logic                               done_o,
  output logic [tsc_pkg::SUM_W-1:0]          tac_sum_o,
  output logic [2:0]                         status_o
);

  tsc_pkg::cfg_t  cfg_q, cfg_d;
  tsc_pkg::item_t head;
  logic           head_valid;
  logic           pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tsc_pkg::reg_idx_e'(cfg_addr_i))
        tsc_pkg::REG_TAC_LOWER:  cfg_d.tac_lower  = cfg_wdata_i;
        tsc_pkg::REG_TAC_UPPER:  cfg_d.tac_upper  = cfg_wdata_i;
        tsc_pkg::REG_DIFF_LIMIT: cfg_d.diff_limit = cfg_wdata_i;
        tsc_pkg::REG_SKIP_EVEN:  cfg_d.skip_even  = cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tac_lower  <= tsc_pkg::SAMPLE_W'(100);
      cfg_q.tac_upper  <= tsc_pkg::SAMPLE_W'(4000);
      cfg_q.diff_limit <= tsc_pkg::SAMPLE_W'(600);
      cfg_q.skip_even  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsc_front #(.BOARDS(BOARDS), .SLEW_BINS(SLEW_BINS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .command_i    (command_i),
    .board_i      (board_i),
    .pair_i       (pair_i),
    .side_i       (side_i),
    .bin_i        (bin_i),
    .load_value_i (load_value_i),
    .tac_first_i  (tac_first_i),
    .tac_second_i (tac_second_i),
    .adc_first_i  (adc_first_i),
    .adc_second_i (adc_second_i),
    .skip_even_i  (cfg_q.skip_even),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .busy_o       (busy_o)
  );

  tsc_back #(.BOARDS(BOARDS), .SLEW_BINS(SLEW_BINS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .done_o       (done_o),
    .tac_sum_o    (tac_sum_o),
    .status_o     (status_o)
  );

  `ASSERT_SAME(a_pop_has_word, pop, head_valid, "executor popped an empty queue")
  `ASSERT_SAME(a_busy_has_word, busy_o, head_valid, "queue full without a head word")
  `ASSERT_SAME(a_reject_zero, done_o && (status_o != tsc_pkg::ST_ACCEPTED), tac_sum_o == '0, "rejected result with nonzero sum")
  `ASSERT_NEXT(a_load_result, pop && (head.kind != tsc_pkg::IT_COMPUTE), done_o, "load or early reject gave no result")

endmodule

`default_nettype wire

[rtl/core/tsc_ram.sv]
`default_nettype none

module tsc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/tsc_front.sv]
`default_nettype none

module tsc_front #(
  parameter int unsigned BOARDS    = 8,
  parameter int unsigned SLEW_BINS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [1:0]                    command_i,
  input  wire logic [tsc_pkg::BOARD_W-1:0]   board_i,
  input  wire logic [tsc_pkg::PAIR_W-1:0]    pair_i,
  input  wire logic                          side_i,
  input  wire logic [tsc_pkg::BINF_W-1:0]    bin_i,
  input  wire logic [tsc_pkg::LOAD_W-1:0]    load_value_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  tac_first_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  tac_second_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  adc_first_i,
  input  wire logic [tsc_pkg::SAMPLE_W-1:0]  adc_second_i,
  input  wire logic                          skip_even_i,
  input  wire logic                          pop_i,
  output tsc_pkg::item_t                     head_o,
  output logic                               head_valid_o,
  output logic                               busy_o
);

  tsc_pkg::item_t              item_new;
  tsc_pkg::item_t              q_mem_q [tsc_pkg::QDEPTH];
  logic                        wr_ptr_q, wr_ptr_d;
  logic                        rd_ptr_q, rd_ptr_d;
  logic [tsc_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        push;
  logic                        full;
  logic                        board_ok;
  logic                        bin_ok;

  assign board_ok = {1'b0, board_i} < 4'(BOARDS);
  assign bin_ok   = {2'b00, bin_i} < 5'(SLEW_BINS);

  // classify
  always_comb begin
    item_new.kind   = tsc_pkg::IT_DIRECT;
    item_new.status = tsc_pkg::ST_LOADED;
    item_new.board  = board_i;
    item_new.pair   = pair_i;
    item_new.side   = side_i;
    item_new.bin    = bin_i;
    item_new.word   = load_value_i[tsc_pkg::CORR_W-1:0];
    item_new.tac0   = tac_first_i;
    item_new.tac1   = tac_second_i;
    item_new.adc0   = adc_first_i;
    item_new.adc1   = adc_second_i;
    unique case (tsc_pkg::command_e'(command_i))
      tsc_pkg::CMD_COMPUTE: begin
        if (skip_even_i && !pair_i[0]) begin
          item_new.status = tsc_pkg::ST_MONITOR;
        end else if (!board_ok) begin
          item_new.status = tsc_pkg::ST_UNMAPPED;
        end else begin
          item_new.kind   = tsc_pkg::IT_COMPUTE;
          item_new.status = tsc_pkg::ST_ACCEPTED;
        end
      end
      tsc_pkg::CMD_LOAD_EDGE: begin
        if (board_ok && bin_ok) item_new.kind = tsc_pkg::IT_EDGE;
      end
      tsc_pkg::CMD_LOAD_CORR: begin
        if (board_ok && bin_ok) item_new.kind = tsc_pkg::IT_CORR;
      end
      tsc_pkg::CMD_LOAD_MAP: begin
        if (board_ok) item_new.kind = tsc_pkg::IT_MAP;
      end
    endcase
  end

  // word queue towards the back end
  assign full         = count_q == tsc_pkg::QCNT_W'(tsc_pkg::QDEPTH);
  assign busy_o       = full;
  assign push         = start_i && !full;
  assign head_valid_o = count_q != '0;
  assign head_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + tsc_pkg::QCNT_W'(1);
    end else if (pop_i && !push) begin
      count_d = count_q - tsc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tsc_back.sv]
`default_nettype none

module tsc_back #(
  parameter int unsigned BOARDS    = 8,
  parameter int unsigned SLEW_BINS = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire tsc_pkg::cfg_t             cfg_i,
  input  wire tsc_pkg::item_t            head_i,
  input  wire logic                      head_valid_i,
  output logic                           pop_o,
  output logic                           done_o,
  output logic [tsc_pkg::SUM_W-1:0]      tac_sum_o,
  output logic [2:0]                     status_o
);

  localparam int unsigned SLEW_DEPTH = BOARDS * tsc_pkg::CHANS * SLEW_BINS;
  localparam int unsigned SAW        = $clog2(SLEW_DEPTH);
  localparam int unsigned MAP_DEPTH  = BOARDS * tsc_pkg::PAIRS;
  localparam int unsigned MAW        = $clog2(MAP_DEPTH);
  localparam int unsigned BIN_W      = (SLEW_BINS > 1) ? $clog2(SLEW_BINS) : 1;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(SLEW_BINS - 1);

  function automatic logic [SAW-1:0] slew_addr(input logic [tsc_pkg::BOARD_W-1:0] board,
                                               input logic [3:0] chan,
                                               input logic [3:0] bin);
    return SAW'(board) * SAW'(tsc_pkg::CHANS * SLEW_BINS) + SAW'(chan) * SAW'(SLEW_BINS)
           + SAW'(bin);
  endfunction

  tsc_pkg::back_state_e         state_q, state_d;
  tsc_pkg::item_t               cur_q;
  logic                         cur_load;
  logic                         side_q, side_d;
  logic [BIN_W-1:0]             bin_q, bin_d;
  logic [tsc_pkg::SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [tsc_pkg::J_W-1:0] j0_q, j0_d, j1_q, j1_d, j_new;
  logic [tsc_pkg::K_W-1:0]      k_q, k_d;
  logic                         done_q, done_d;
  logic [tsc_pkg::SUM_W-1:0]    sum_q, sum_d;
  tsc_pkg::status_e             status_q, status_d;

  logic                         edge_we, corr_we, map_we, slew_re, map_re;
  logic [SAW-1:0]               slew_waddr, slew_raddr;
  logic [MAW-1:0]               map_addr;
  logic [tsc_pkg::BOARD_W-1:0]  rd_board;
  logic [tsc_pkg::PAIR_W-1:0]   rd_pair;
  logic [tsc_pkg::SAMPLE_W-1:0] edge_rd;
  logic [tsc_pkg::CORR_W-1:0]   corr_rd;
  logic [tsc_pkg::MAP_W-1:0]    map_rd;

  logic [tsc_pkg::SAMPLE_W-1:0] adc_cur, tac_cur;
  logic                         match, side_done;
  logic signed [tsc_pkg::J_W-1:0]    lower_s, upper_s;
  logic signed [tsc_pkg::DIFF_W-1:0] diff, diff_abs, limit_s;
  logic                         reject;
  logic signed [tsc_pkg::NUM_W-1:0]  num;
  logic [tsc_pkg::NUM_W-1:0]    num_pos;

  assign rd_board   = (state_q == tsc_pkg::BK_IDLE) ? head_i.board : cur_q.board;
  assign rd_pair    = (state_q == tsc_pkg::BK_IDLE) ? head_i.pair  : cur_q.pair;
  assign slew_waddr = slew_addr(head_i.board, {head_i.pair, head_i.side}, {1'b0, head_i.bin});
  assign slew_raddr = slew_addr(rd_board, {rd_pair, side_d}, 4'(bin_d));
  assign map_addr   = MAW'({head_i.board, head_i.pair});

  tsc_ram #(.WIDTH(tsc_pkg::SAMPLE_W), .DEPTH(SLEW_DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (slew_waddr),
    .wdata_i (head_i.word),
    .re_i    (slew_re),
    .raddr_i (slew_raddr),
    .rdata_o (edge_rd)
  );

  tsc_ram #(.WIDTH(tsc_pkg::CORR_W), .DEPTH(SLEW_DEPTH)) u_corr_ram (
    .clk_i   (clk_i),
    .we_i    (corr_we),
    .waddr_i (slew_waddr),
    .wdata_i (head_i.word),
    .re_i    (slew_re),
    .raddr_i (slew_raddr),
    .rdata_o (corr_rd)
  );

  tsc_ram #(.WIDTH(tsc_pkg::MAP_W), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_addr),
    .wdata_i (head_i.word[tsc_pkg::MAP_W-1:0]),
    .re_i    (map_re),
    .raddr_i (map_addr),
    .rdata_o (map_rd)
  );

  // bin scan, one edge and its correction per cycle
  assign adc_cur   = side_q ? cur_q.adc1 : cur_q.adc0;
  assign tac_cur   = side_q ? cur_q.tac1 : cur_q.tac0;
  assign match     = (adc_cur > prev_q) && (adc_cur <= edge_rd);
  assign side_done = match || (bin_q == LAST_BIN);
  assign j_new     = $signed({2'b00, tac_cur})
                   + (match ? tsc_pkg::J_W'($signed(corr_rd)) : '0);

  // window and difference
  assign lower_s  = $signed({2'b00, cfg_i.tac_lower});
  assign upper_s  = $signed({2'b00, cfg_i.tac_upper});
  assign limit_s  = $signed({3'b000, cfg_i.diff_limit});
  assign diff     = tsc_pkg::DIFF_W'(j0_q) - tsc_pkg::DIFF_W'(j1_q);
  assign diff_abs = diff[tsc_pkg::DIFF_W-1] ? -diff : diff;
  assign reject   = (j0_q <= lower_s) || (j0_q >= upper_s) || (j1_q <= lower_s)
                 || (j1_q >= upper_s) || (diff_abs >= limit_s);

  // position correction, eighths kept in integer
  assign num = ((tsc_pkg::NUM_W'(j0_q) + tsc_pkg::NUM_W'(j1_q)) <<< tsc_pkg::SUM_SHIFT)
             + tsc_pkg::NUM_W'($signed({1'b0, k_q})) * tsc_pkg::NUM_W'(diff);
  assign num_pos = num[tsc_pkg::NUM_W-1] ? '0 : num;

  always_comb begin
    state_d  = state_q;
    side_d   = side_q;
    bin_d    = bin_q;
    prev_d   = prev_q;
    j0_d     = j0_q;
    j1_d     = j1_q;
    k_d      = k_q;
    done_d   = 1'b0;
    sum_d    = sum_q;
    status_d = status_q;
    cur_load = 1'b0;
    pop_o    = 1'b0;
    edge_we  = 1'b0;
    corr_we  = 1'b0;
    map_we   = 1'b0;
    slew_re  = 1'b0;
    map_re   = 1'b0;
    unique case (state_q)
      tsc_pkg::BK_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.kind)
            tsc_pkg::IT_COMPUTE: begin
              cur_load = 1'b1;
              side_d   = 1'b0;
              bin_d    = '0;
              prev_d   = '0;
              slew_re  = 1'b1;
              map_re   = 1'b1;
              state_d  = tsc_pkg::BK_SCAN;
            end
            tsc_pkg::IT_EDGE, tsc_pkg::IT_CORR, tsc_pkg::IT_MAP: begin
              edge_we  = head_i.kind == tsc_pkg::IT_EDGE;
              corr_we  = head_i.kind == tsc_pkg::IT_CORR;
              map_we   = head_i.kind == tsc_pkg::IT_MAP;
              done_d   = 1'b1;
              sum_d    = '0;
              status_d = tsc_pkg::ST_LOADED;
            end
            default: begin
              done_d   = 1'b1;
              sum_d    = '0;
              status_d = head_i.status;
            end
          endcase
        end
      end
      tsc_pkg::BK_SCAN: begin
        slew_re = 1'b1;
        if (side_done) begin
          bin_d  = '0;
          prev_d = '0;
          if (!side_q) begin
            j0_d   = j_new;
            side_d = 1'b1;
          end else begin
            j1_d    = j_new;
            state_d = tsc_pkg::BK_CHECK;
          end
        end else begin
          bin_d  = bin_q + BIN_W'(1);
          prev_d = edge_rd;
        end
      end
      tsc_pkg::BK_CHECK: begin
        if (reject) begin
          done_d   = 1'b1;
          sum_d    = '0;
          status_d = tsc_pkg::ST_WINDOW;
          state_d  = tsc_pkg::BK_IDLE;
        end else if (map_rd[tsc_pkg::MAP_W-1]) begin
          done_d   = 1'b1;
          sum_d    = '0;
          status_d = tsc_pkg::ST_UNMAPPED;
          state_d  = tsc_pkg::BK_IDLE;
        end else begin
          k_d = (map_rd >= tsc_pkg::MAP_W'(tsc_pkg::MODULE_MID))
              ? tsc_pkg::K_W'(map_rd - tsc_pkg::MAP_W'(tsc_pkg::MODULE_MID))
              : tsc_pkg::K_W'(tsc_pkg::MAP_W'(tsc_pkg::MODULE_MID) - map_rd);
          state_d = tsc_pkg::BK_MATH;
        end
      end
      tsc_pkg::BK_MATH: begin
        done_d   = 1'b1;
        sum_d    = num_pos[tsc_pkg::SUM_SHIFT +: tsc_pkg::SUM_W];
        status_d = tsc_pkg::ST_ACCEPTED;
        state_d  = tsc_pkg::BK_IDLE;
      end
      default: begin
        state_d = tsc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) begin
      cur_q <= head_i;
    end
    side_q   <= side_d;
    bin_q    <= bin_d;
    prev_q   <= prev_d;
    j0_q     <= j0_d;
    j1_q     <= j1_d;
    k_q      <= k_d;
    sum_q    <= sum_d;
    status_q <= status_d;
  end

  assign done_o    = done_q;
  assign tac_sum_o = sum_q;
  assign status_o  = status_q;

endmodule

`default_nettype wire
